[src/isu_pkg.sv]
// Shared types and constants for the Ising Metropolis spin update block.
// Lattice geometry, field widths, register indexes, opcodes and sequencer states.
// No dependencies.
`default_nettype none

package isu_pkg;

  // Lattice geometry
  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ROW_W        = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;

  // Field widths
  localparam int SITE_W     = 12;
  localparam int DRAW_W     = 20;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 15;
  localparam int MAG_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Reciprocal of the side for splitting a site into row and column
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 24;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / LATTICE_SIDE);

  // Totals after reset: every spin down
  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITE_COUNT);
  localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(-SITE_COUNT);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INF_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_4  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_8  = 2'd2;

  // Opcodes
  localparam logic OP_ATTEMPT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Energy change that selects the first limit
  localparam logic signed [DE_W-1:0] DE_FOUR = 5'sd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT_A,
    ST_SPLIT_B,
    ST_RD_CUR,
    ST_RD_UP,
    ST_RD_DOWN,
    ST_DECIDE
  } state_t;

  // Position of a site and its neighbours in the row memory
  typedef struct packed {
    logic             in_range;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_up;
    logic [ROW_W-1:0] row_down;
    logic [ROW_W-1:0] col;
    logic [ROW_W-1:0] col_left;
    logic [ROW_W-1:0] col_right;
  } site_pos_t;

endpackage

`default_nettype wire

[src/ising_metropolis_spin_update.sv]
// Top level of the Ising Metropolis spin update: sequencer, acceptance test and totals.
// Lattice rows live in isu_row_ram; site decode in isu_site_split. Depends on isu_pkg.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, opcode site draw spin  inbound transaction
//   out       out_valid/out_ready, accepted delta_energy outbound transaction
//             energy magnetization spin_now
//   cfg       cfg_write, cfg_index, cfg_data            register write, no handshake
//
// Each transaction runs from one acceptance to the next: SPLIT_A and SPLIT_B split the
// site into row and column, three single-port reads of the row memory (own row, row
// above, row below) in RD_CUR, RD_UP and RD_DOWN, DECIDE decides and writes the row back,
// then IDLE. After reset a clearing pass writes LATTICE_SIDE rows with in_ready low.
// A result waiting at the output stalls the decide step until out_ready takes it.
`default_nettype none

module ising_metropolis_spin_update (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [isu_pkg::SITE_W-1:0]     site,
  input  wire logic [isu_pkg::DRAW_W-1:0]     draw,
  input  wire logic                          spin_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               accepted,
  output logic signed [isu_pkg::DE_W-1:0]     delta_energy,
  output logic signed [isu_pkg::ENERGY_W-1:0] energy,
  output logic signed [isu_pkg::MAG_W-1:0]    magnetization,
  output logic                               spin_now,
  input  wire logic                          cfg_write,
  input  wire logic [isu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [isu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import isu_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LATTICE_SIDE - 1);

  state_t state;
  state_t state_next;

  // Configuration
  logic              inf_temp;
  logic [DRAW_W-1:0] limit_four;
  logic [DRAW_W-1:0] limit_eight;

  // Held transaction
  logic              op_q;
  logic [SITE_W-1:0] site_q;
  logic [DRAW_W-1:0] draw_q;
  logic              value_q;

  site_pos_t pos;

  // Row memory ports
  logic                    ram_wr_en;
  logic [ROW_W-1:0]        ram_wr_addr;
  logic [LATTICE_SIDE-1:0] ram_wr_data;
  logic                    ram_rd_en;
  logic [ROW_W-1:0]        ram_rd_addr;
  logic [LATTICE_SIDE-1:0] ram_rd_data;

  logic [LATTICE_SIDE-1:0] cur_row;
  logic                    up_bit;
  logic [ROW_W-1:0]        clear_row;

  logic [ENERGY_W-1:0] total_energy;
  logic [MAG_W-1:0]    total_mag;

  // Decide step
  logic                   slot_free;
  logic                   do_decide;
  logic                   s_bit;
  logic [2:0]             ups;
  logic signed [5:0]      de_up;
  logic signed [5:0]      de_wide;
  logic signed [DE_W-1:0] de;
  logic                   de_pos;
  logic                   change_raw;
  logic                   change;
  logic                   new_spin;
  logic [ENERGY_W-1:0]    energy_next;
  logic [MAG_W-1:0]       mag_next;

  isu_row_ram #(
    .WIDTH (LATTICE_SIDE),
    .DEPTH (LATTICE_SIDE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  isu_site_split u_split (
    .clk  (clk),
    .site (site_q),
    .pos  (pos)
  );

  assign slot_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clear_row == LAST_ROW) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = ST_SPLIT_A;
      ST_SPLIT_A: state_next = ST_SPLIT_B;
      ST_SPLIT_B: state_next = ST_RD_CUR;
      ST_RD_CUR:  state_next = ST_RD_UP;
      ST_RD_UP:   state_next = ST_RD_DOWN;
      ST_RD_DOWN: state_next = ST_DECIDE;
      ST_DECIDE:  if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = pos.row;
    do_decide   = 1'b0;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_RD_CUR:  ram_rd_en = 1'b1;
      ST_RD_UP: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos.row_up;
      end
      ST_RD_DOWN: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos.row_down;
      end
      ST_DECIDE:  do_decide = slot_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_row <= '0;
    end else if (state == ST_CLEAR) begin
      clear_row <= clear_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inf_temp    <= 1'b0;
      limit_four  <= '0;
      limit_eight <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INF_TEMP: inf_temp    <= cfg_data[0];
        CFG_LIMIT_4:  limit_four  <= cfg_data;
        CFG_LIMIT_8:  limit_eight <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= opcode;
      site_q  <= site;
      draw_q  <= draw;
      value_q <= spin_value;
    end
  end

  // Capture own row and the upper neighbour as they come out of the memory
  always_ff @(posedge clk) begin
    if (state == ST_RD_UP) begin
      cur_row <= ram_rd_data;
    end
    if (state == ST_RD_DOWN) begin
      up_bit <= ram_rd_data[pos.col];
    end
  end

  // Acceptance test; the memory output now holds the row below
  always_comb begin
    s_bit   = cur_row[pos.col];
    ups     = 3'(up_bit) + 3'(ram_rd_data[pos.col]) + 3'(cur_row[pos.col_left])
            + 3'(cur_row[pos.col_right]);
    de_up   = $signed({1'b0, ups, 2'b00}) - 6'sd8;
    de_wide = s_bit ? de_up : -de_up;
    de      = de_wide[DE_W-1:0];
    de_pos  = !de[DE_W-1] && (de != '0);
    if (op_q == OP_ATTEMPT) begin
      if (inf_temp || !de_pos) begin
        change_raw = 1'b1;
      end else if (de == DE_FOUR) begin
        change_raw = draw_q < limit_four;
      end else begin
        change_raw = draw_q < limit_eight;
      end
    end else begin
      change_raw = s_bit != value_q;
    end
    change      = pos.in_range && change_raw;
    new_spin    = s_bit ^ change;
    energy_next = change ? total_energy + {{(ENERGY_W-DE_W){de[DE_W-1]}}, de} : total_energy;
    if (!change) begin
      mag_next = total_mag;
    end else if (new_spin) begin
      mag_next = total_mag + MAG_W'(2);
    end else begin
      mag_next = total_mag - MAG_W'(2);
    end
  end

  // Row write-back, or zero rows during the clearing pass
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clear_row;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = do_decide && change;
      ram_wr_addr = pos.row;
      ram_wr_data = cur_row ^ (LATTICE_SIDE'(1) << pos.col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_energy <= ENERGY_RESET;
      total_mag    <= MAG_RESET;
    end else if (do_decide) begin
      total_energy <= energy_next;
      total_mag    <= mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_decide) begin
      accepted      <= change;
      delta_energy  <= pos.in_range ? de : '0;
      energy        <= energy_next;
      magnetization <= mag_next;
      spin_now      <= pos.in_range && new_spin;
    end
  end

endmodule

`default_nettype wire

[src/isu_row_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds when no read is issued. No package dependency.
`default_nettype none

module isu_row_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                  wr_data,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/isu_site_split.sv]
// Two-stage split of a site index into row, column and periodic neighbours.
// Uses a reciprocal multiply with one correction step. Depends on isu_pkg.
`default_nettype none

module isu_site_split (
  input  wire logic                      clk,
  input  wire logic [isu_pkg::SITE_W-1:0] site,
  output isu_pkg::site_pos_t             pos
);
  import isu_pkg::*;

  localparam logic [SITE_W-1:0] SIDE_S = SITE_W'(LATTICE_SIDE);
  localparam logic [ROW_W-1:0]  LAST   = ROW_W'(LATTICE_SIDE - 1);

  logic [SITE_W+RECIP_W-1:0] prod;
  logic [SITE_W-1:0]         row_est;
  logic [SITE_W-1:0]         site_d;
  logic                      in_range_d;

  logic [SITE_W-1:0] base;
  logic [SITE_W-1:0] col_tmp;
  logic [SITE_W-1:0] row_fix;
  logic [SITE_W-1:0] col_fix;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  col;
  site_pos_t         pos_next;

  assign prod = (SITE_W+RECIP_W)'(site) * (SITE_W+RECIP_W)'(RECIP);

  // Stage A: estimate of the row, at most one short
  always_ff @(posedge clk) begin
    row_est    <= prod[RECIP_SH +: SITE_W];
    site_d     <= site;
    in_range_d <= (32'(site) < 32'(SITE_COUNT));
  end

  // Stage B: correct the estimate and wrap the neighbours
  always_comb begin
    base    = SITE_W'(row_est * SIDE_S);
    col_tmp = site_d - base;
    if (col_tmp >= SIDE_S) begin
      row_fix = row_est + SITE_W'(1);
      col_fix = col_tmp - SIDE_S;
    end else begin
      row_fix = row_est;
      col_fix = col_tmp;
    end
    row = row_fix[ROW_W-1:0];
    col = col_fix[ROW_W-1:0];
    pos_next.in_range  = in_range_d;
    pos_next.row       = row;
    pos_next.col       = col;
    pos_next.row_up    = (row == '0)   ? LAST : row - ROW_W'(1);
    pos_next.row_down  = (row == LAST) ? '0   : row + ROW_W'(1);
    pos_next.col_left  = (col == '0)   ? LAST : col - ROW_W'(1);
    pos_next.col_right = (col == LAST) ? '0   : col + ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
  end

endmodule

`default_nettype wire
